// ===== design/perspective_point_projection_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the perspective point projection block
// Shared forms for concurrent checks clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PERSPECTIVE_POINT_PROJECTION_ASSERT_SVH
`define PERSPECTIVE_POINT_PROJECTION_ASSERT_SVH

// Same-cycle implication.
`define PPP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("perspective_point_projection: assertion failed");

// Next-cycle implication.
`define PPP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("perspective_point_projection: assertion failed");

`endif

// ===== design/ppp_pkg.sv =====
// ----------------------------------------------------------------------------
// ppp_pkg
// Register indexes of the perspective point projection block.
// ----------------------------------------------------------------------------
package ppp_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X    = 3'd0,
        CFG_ORIGIN_Y    = 3'd1,
        CFG_ORIGIN_Z    = 3'd2,
        CFG_RIGHT_AXIS  = 3'd3,
        CFG_UP_AXIS     = 3'd4,
        CFG_VIEW_AXIS   = 3'd5,
        CFG_FOCAL_SCALE = 3'd6
    } t_cfg_idx;

endpackage

// ===== design/ppp_div.sv =====
// ----------------------------------------------------------------------------
// ppp_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module ppp_div #(
    parameter int SW = 53,
    parameter int QW = 32
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [SW-1:0] i_rem,
    input  logic [QW-1:0] i_lo,
    input  logic [SW-1:0] i_dv,
    output logic [QW-1:0] o_q
);

    logic [SW-1:0] r_rem [QW];
    logic [QW-1:0] r_lo  [QW];
    logic [SW-1:0] r_dv  [QW];
    logic [QW-1:0] r_q   [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic [SW-1:0] w_rem;
        logic [QW-1:0] w_lo;
        logic [SW-1:0] w_dv;
        logic [QW-1:0] w_q;
        logic [SW:0]   w_t;
        logic          w_ge;

        if (g == 0) begin : g_first
            assign w_rem = i_rem;
            assign w_lo  = i_lo;
            assign w_dv  = i_dv;
            assign w_q   = '0;
        end else begin : g_next
            assign w_rem = r_rem[g-1];
            assign w_lo  = r_lo[g-1];
            assign w_dv  = r_dv[g-1];
            assign w_q   = r_q[g-1];
        end

        // The partial remainder stays below the divisor, so the shifted
        // value fits one bit more than the divisor.
        assign w_t  = {w_rem, w_lo[QW-1]};
        assign w_ge = w_t >= {1'b0, w_dv};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g] <= w_ge ? SW'(w_t - {1'b0, w_dv}) : w_t[SW-1:0];
                r_lo[g]  <= {w_lo[QW-2:0], 1'b0};
                r_dv[g]  <= w_dv;
                r_q[g]   <= {w_q[QW-2:0], w_ge};
            end
        end
    end

    assign o_q = r_q[QW-1];

endmodule

// ===== design/perspective_point_projection.sv =====
// ----------------------------------------------------------------------------
// perspective_point_projection
// Pinhole camera projection of one Q16.16 world point per request.
// ----------------------------------------------------------------------------
// The block accepts one point per clock and returns one result per point, in
// order. From an accepted input request to output valid, a point passes
// seven arithmetic stages (offset, axis products, dot sums, magnitudes,
// split focal product, product sum, overflow check), then a restoring
// divider that resolves one quotient bit per register stage, and the output
// register. A two-entry output buffer lets the block keep taking points while
// a result waits; input is held off only while that buffer is full.
// Configuration is written through i_cfg_we/i_cfg_idx and must only change
// while no point is in flight.
`include "perspective_point_projection_assert.svh"

module perspective_point_projection #(
    parameter int COORD_WIDTH    = 32,
    parameter int AXIS_FRAC_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [ppp_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [((COORD_WIDTH > 3*(AXIS_FRAC_BITS+2)) ? COORD_WIDTH
                  : 3*(AXIS_FRAC_BITS+2))-1:0] i_cfg_data,
    // Point input: point_x, point_y, point_z from the lowest bit up.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((3*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // Result: screen_x, screen_y, depth_out from the lowest bit up.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((3*COORD_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    // Result flag: behind.
    output logic                                  m_axis_tuser
);

    localparam int CW   = COORD_WIDTH;
    localparam int AW   = AXIS_FRAC_BITS + 2;
    localparam int XW   = 3 * AW;
    localparam int DW   = CW + 1;
    localparam int PW   = AW + DW;
    localparam int SW   = PW + 2;
    localparam int SL   = SW / 2;
    localparam int SH   = SW - SL;
    localparam int MW   = CW + SW;
    localparam int OW   = ((3 * CW + 7) / 8) * 8;
    localparam int NFR  = 7;
    localparam int NST  = NFR + CW;

    typedef struct packed {
        logic          behind;
        logic          neg_x;
        logic          neg_y;
        logic          big_x;
        logic          big_y;
        logic [CW-1:0] dz;
    } t_side;

    typedef struct packed {
        logic [CW-1:0] sx;
        logic [CW-1:0] sy;
        logic [CW-1:0] dz;
        logic          behind;
    } t_res;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [CW-1:0] r_org [3];
    logic [XW-1:0]        r_right, r_up, r_view;
    logic signed [CW-1:0] r_focal;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org[0] <= '0;
            r_org[1] <= '0;
            r_org[2] <= '0;
            r_right  <= XW'(1) << AXIS_FRAC_BITS;
            r_up     <= XW'(1) << (AXIS_FRAC_BITS + AW);
            r_view   <= XW'(1) << (AXIS_FRAC_BITS + 2 * AW);
            r_focal  <= {CW{1'b1}} << 16;
        end else if (i_cfg_we) begin
            unique case (ppp_pkg::t_cfg_idx'(i_cfg_idx))
                ppp_pkg::CFG_ORIGIN_X:    r_org[0] <= i_cfg_data[CW-1:0];
                ppp_pkg::CFG_ORIGIN_Y:    r_org[1] <= i_cfg_data[CW-1:0];
                ppp_pkg::CFG_ORIGIN_Z:    r_org[2] <= i_cfg_data[CW-1:0];
                ppp_pkg::CFG_RIGHT_AXIS:  r_right  <= i_cfg_data[XW-1:0];
                ppp_pkg::CFG_UP_AXIS:     r_up     <= i_cfg_data[XW-1:0];
                ppp_pkg::CFG_VIEW_AXIS:   r_view   <= i_cfg_data[XW-1:0];
                ppp_pkg::CFG_FOCAL_SCALE: r_focal  <= i_cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: everything advances unless the output buffer is full.
    // ------------------------------------------------------------------
    logic           r_sk_vld, r_o_vld;
    logic           w_en;
    logic [NST-1:0] r_vld;

    assign w_en          = !r_sk_vld;
    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    // Stage 1: offset from the origin.
    logic signed [DW-1:0] r1_d [3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r1_d[k] <= DW'(r_org[k]) - DW'($signed(s_axis_tdata[k*CW +: CW]));
            end
        end
    end

    // Stage 2: axis products and saturated depth.
    logic signed [PW-1:0] r2_pr [3], r2_pu [3], r2_pv [3];
    logic [CW-1:0]        r2_dz;
    logic signed [DW:0]   w_negz;
    localparam logic signed [DW:0] ZMAX = (DW+1)'((64'd1 << (CW - 1)) - 64'd1);
    localparam logic signed [DW:0] ZMIN = -ZMAX - (DW+1)'(1);

    assign w_negz = -((DW+1)'(r1_d[2]));

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r2_pr[k] <= PW'($signed(r_right[k*AW +: AW])) * PW'(r1_d[k]);
                r2_pu[k] <= PW'($signed(r_up[k*AW +: AW]))    * PW'(r1_d[k]);
                r2_pv[k] <= PW'($signed(r_view[k*AW +: AW]))  * PW'(r1_d[k]);
            end
            if (w_negz > ZMAX) begin
                r2_dz <= ZMAX[CW-1:0];
            end else if (w_negz < ZMIN) begin
                r2_dz <= ZMIN[CW-1:0];
            end else begin
                r2_dz <= w_negz[CW-1:0];
            end
        end
    end

    // Stage 3: dot products.
    logic signed [SW-1:0] r3_nx, r3_ny, r3_dp;
    logic [CW-1:0]        r3_dz;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_nx <= SW'(r2_pr[0]) + SW'(r2_pr[1]) + SW'(r2_pr[2]);
            r3_ny <= SW'(r2_pu[0]) + SW'(r2_pu[1]) + SW'(r2_pu[2]);
            r3_dp <= SW'(r2_pv[0]) + SW'(r2_pv[1]) + SW'(r2_pv[2]);
            r3_dz <= r2_dz;
        end
    end

    // Stage 4: magnitudes and result signs. The depth is negative whenever
    // a division is used, which flips the sign once.
    logic [CW-1:0] r4_cm;
    logic [SW-1:0] r4_mx, r4_my, r4_dv;
    t_side         r4_sd;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_cm        <= r_focal[CW-1] ? CW'(-r_focal) : CW'(r_focal);
            r4_mx        <= r3_nx[SW-1] ? SW'(-r3_nx) : SW'(r3_nx);
            r4_my        <= r3_ny[SW-1] ? SW'(-r3_ny) : SW'(r3_ny);
            r4_dv        <= r3_dp[SW-1] ? SW'(-r3_dp) : SW'(r3_dp);
            r4_sd.behind <= !r3_dp[SW-1];
            r4_sd.neg_x  <= !(r_focal[CW-1] ^ r3_nx[SW-1]);
            r4_sd.neg_y  <= !(r_focal[CW-1] ^ r3_ny[SW-1]);
            r4_sd.big_x  <= 1'b0;
            r4_sd.big_y  <= 1'b0;
            r4_sd.dz     <= r3_dz;
        end
    end

    // Stage 5: focal scale times numerator, split into two partial products.
    logic [CW+SL-1:0] r5_xl, r5_yl;
    logic [CW+SH-1:0] r5_xh, r5_yh;
    logic [SW-1:0]    r5_dv;
    t_side            r5_sd;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_xl <= (CW+SL)'(r4_cm) * (CW+SL)'(r4_mx[SL-1:0]);
            r5_xh <= (CW+SH)'(r4_cm) * (CW+SH)'(r4_mx[SW-1:SL]);
            r5_yl <= (CW+SL)'(r4_cm) * (CW+SL)'(r4_my[SL-1:0]);
            r5_yh <= (CW+SH)'(r4_cm) * (CW+SH)'(r4_my[SW-1:SL]);
            r5_dv <= r4_dv;
            r5_sd <= r4_sd;
        end
    end

    // Stage 6: full dividends.
    logic [MW-1:0] r6_px, r6_py;
    logic [SW-1:0] r6_dv;
    t_side         r6_sd;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_px <= MW'(r5_xl) + (MW'(r5_xh) << SL);
            r6_py <= MW'(r5_yl) + (MW'(r5_yh) << SL);
            r6_dv <= r5_dv;
            r6_sd <= r5_sd;
        end
    end

    // Stage 7: a quotient that needs more than COORD_WIDTH bits saturates;
    // otherwise the upper dividend part is already the first remainder.
    logic [SW-1:0] r7_rx, r7_ry, r7_dv;
    logic [CW-1:0] r7_lx, r7_ly;
    t_side         r7_sd;
    logic          w_big_x, w_big_y;

    assign w_big_x = r6_px[MW-1:CW] >= r6_dv;
    assign w_big_y = r6_py[MW-1:CW] >= r6_dv;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_rx <= w_big_x ? '0 : r6_px[MW-1:CW];
            r7_ry <= w_big_y ? '0 : r6_py[MW-1:CW];
            r7_lx <= r6_px[CW-1:0];
            r7_ly <= r6_py[CW-1:0];
            r7_dv <= r6_dv;
            r7_sd <= {r6_sd.behind, r6_sd.neg_x, r6_sd.neg_y, w_big_x, w_big_y, r6_sd.dz};
        end
    end

    // Dividers and the side data that travels beside them.
    logic [CW-1:0] w_qx, w_qy;
    t_side         r_sd_div [CW];

    ppp_div #(.SW(SW), .QW(CW)) u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem (r7_rx),
        .i_lo  (r7_lx),
        .i_dv  (r7_dv),
        .o_q   (w_qx)
    );

    ppp_div #(.SW(SW), .QW(CW)) u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem (r7_ry),
        .i_lo  (r7_ly),
        .i_dv  (r7_dv),
        .o_q   (w_qy)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd_div[0] <= r7_sd;
            for (int k = 1; k < CW; k++) begin
                r_sd_div[k] <= r_sd_div[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Saturation, sign and behind-plane masking.
    // ------------------------------------------------------------------
    localparam logic [CW-1:0] QLIM = CW'(1) << (CW - 1);

    function automatic logic [CW-1:0] sat_q(logic [CW-1:0] q, logic neg, logic big);
        logic [CW-1:0] res;
        if (neg) begin
            res = (big || q > QLIM) ? QLIM : CW'(-q);
        end else begin
            res = (big || q[CW-1]) ? (QLIM - CW'(1)) : q;
        end
        return res;
    endfunction

    t_side w_sd;
    t_res  w_res;

    assign w_sd = r_sd_div[CW-1];

    always_comb begin
        w_res.behind = w_sd.behind;
        if (w_sd.behind) begin
            w_res.sx = '0;
            w_res.sy = '0;
            w_res.dz = '0;
        end else begin
            w_res.sx = sat_q(w_qx, w_sd.neg_x, w_sd.big_x);
            w_res.sy = sat_q(w_qy, w_sd.neg_y, w_sd.big_y);
            w_res.dz = w_sd.dz;
        end
    end

    // ------------------------------------------------------------------
    // Output register with a skid entry behind it.
    // ------------------------------------------------------------------
    t_res r_o, r_sk;
    logic w_pop, w_arr;

    assign w_pop = r_o_vld && m_axis_tready;
    assign w_arr = w_en && r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld  <= 1'b0;
            r_sk_vld <= 1'b0;
        end else if (r_sk_vld) begin
            if (w_pop) begin
                r_sk_vld <= 1'b0;
            end
        end else if (w_arr) begin
            if (!r_o_vld || w_pop) begin
                r_o_vld <= 1'b1;
            end else begin
                r_sk_vld <= 1'b1;
            end
        end else if (w_pop) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_vld) begin
            if (w_pop) begin
                r_o <= r_sk;
            end
        end else if (w_arr) begin
            if (!r_o_vld || w_pop) begin
                r_o <= w_res;
            end else begin
                r_sk <= w_res;
            end
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = OW'({r_o.dz, r_o.sy, r_o.sx});
    assign m_axis_tuser  = r_o.behind;

    `PPP_ASSERT_IMP(a_skid_needs_out, r_sk_vld, r_o_vld)
    `PPP_ASSERT_NXT(a_skid_drains, r_sk_vld && m_axis_tready, r_o_vld && !r_sk_vld)
    `PPP_ASSERT_NXT(a_stall_keeps, r_o_vld && !m_axis_tready, r_o_vld)
    `PPP_ASSERT_IMP(a_behind_zero, r_o_vld && r_o.behind, {r_o.sx, r_o.sy, r_o.dz} == '0)

endmodule
